// ===== hw/rtl/stft_pkg.sv =====
// Package for the complex STFT spectrogram: shared types, constants and the twiddle table.
// It depends on nothing; stft_mac and the top level use it by scoped names.
package stft_pkg;

  localparam int TW_W = 17;
  localparam int SHIFT = 15;
  localparam logic [TW_W-1:0] ONE_Q15 = 17'd32768;

  localparam logic [1:0] REG_FRAME_LENGTH = 2'd0;
  localparam logic [1:0] REG_HOP_LENGTH   = 2'd1;
  localparam logic [1:0] REG_FFT_LOG2     = 2'd2;
  localparam logic [1:0] REG_TAPER_ENABLE = 2'd3;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctrl_t;

  localparam logic [TW_W-1:0] QUARTER_COS [17] = '{
    17'd32768, 17'd32610, 17'd32138, 17'd31357, 17'd30274, 17'd28899, 17'd27246,
    17'd25330, 17'd23170, 17'd20788, 17'd18205, 17'd15447, 17'd12540, 17'd9512,
    17'd6393, 17'd3212, 17'd0
  };

  function automatic logic signed [TW_W-1:0] cos64(input logic [5:0] k);
    logic [6:0] kk;
    logic signed [TW_W-1:0] r;
    kk = {1'b0, k};
    if (kk <= 7'd16) begin
      r = QUARTER_COS[kk[4:0]];
    end else if (kk <= 7'd32) begin
      r = -QUARTER_COS[5'(7'd32 - kk)];
    end else if (kk <= 7'd48) begin
      r = -QUARTER_COS[5'(kk - 7'd32)];
    end else begin
      r = QUARTER_COS[5'(7'd64 - kk)];
    end
    return r;
  endfunction

  function automatic logic signed [TW_W-1:0] sin64(input logic [5:0] k);
    return cos64(k + 6'd48);
  endfunction

endpackage

// ===== hw/rtl/stft_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// It depends on nothing.
module stft_ram #(
  parameter int W = 16,
  parameter int D = 64
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/stft_mac.sv =====
// Shared complex multiply-accumulate unit: a registered product stage and an accumulator.
// It depends on stft_pkg for the control struct and the twiddle width.
module stft_mac #(
  parameter int A_W   = 17,
  parameter int ACC_W = 42
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  stft_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [A_W-1:0]               a_re_i,
  input  logic signed [A_W-1:0]               a_im_i,
  input  logic signed [stft_pkg::TW_W-1:0]    c_i,
  input  logic signed [stft_pkg::TW_W-1:0]    s_i,
  output logic                                res_valid_o,
  output logic                                res_last_o,
  output logic signed [ACC_W-1:0]             acc_re_o,
  output logic signed [ACC_W-1:0]             acc_im_o
);

  localparam int P_W = A_W + stft_pkg::TW_W;

  logic signed [P_W-1:0] p_ac_q, p_bs_q, p_bc_q, p_as_q;
  stft_pkg::mac_ctrl_t   c1_q;
  logic                  v2_q, l2_q;
  logic signed [ACC_W-1:0] acc_re_q, acc_re_d, acc_im_q, acc_im_d;
  logic signed [P_W:0]   sum_re, sum_im;

  always_ff @(posedge clk_i) begin
    p_ac_q <= a_re_i * c_i;
    p_bs_q <= a_im_i * s_i;
    p_bc_q <= a_im_i * c_i;
    p_as_q <= a_re_i * s_i;
    acc_re_q <= acc_re_d;
    acc_im_q <= acc_im_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      v2_q <= 1'b0;
      l2_q <= 1'b0;
    end else begin
      c1_q <= ctrl_i;
      v2_q <= c1_q.valid;
      l2_q <= c1_q.last;
    end
  end

  always_comb begin
    sum_re = (P_W+1)'(p_ac_q) + (P_W+1)'(p_bs_q);
    sum_im = (P_W+1)'(p_bc_q) - (P_W+1)'(p_as_q);
    acc_re_d = acc_re_q;
    acc_im_d = acc_im_q;
    if (c1_q.valid) begin
      if (c1_q.first) begin
        acc_re_d = ACC_W'(sum_re);
        acc_im_d = ACC_W'(sum_im);
      end else begin
        acc_re_d = acc_re_q + ACC_W'(sum_re);
        acc_im_d = acc_im_q + ACC_W'(sum_im);
      end
    end
  end

  assign res_valid_o = v2_q;
  assign res_last_o  = l2_q;
  assign acc_re_o    = acc_re_q;
  assign acc_im_o    = acc_im_q;

endmodule

// ===== hw/rtl/complex_stft_spectrogram.sv =====
// Complex STFT spectrogram: framing, taper pass and direct DFT on one shared MAC unit.
// A window runs a taper pass into a work RAM, then a DFT pass over it for each bin,
// followed by its output handshake; no sample is taken until the last bin is sent.
// Samples that close no window and load commands do not stall. Reset is asynchronous,
// active low, and clears the control and framing state; the RAM contents are undefined
// until written. Depends on stft_pkg, stft_ram and stft_mac.
module complex_stft_spectrogram #(
  parameter int MAX_FFT_POINTS = 64,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // sample_re, sample_im, coef_index, coef_value
  input  logic [((2*SAMPLE_BITS+22+7)/8)*8-1:0] s_axis_tdata,
  // command
  input  logic s_axis_tuser,
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // bin_re, bin_im, bin_number, frame_number
  output logic [71:0] m_axis_tdata,
  output logic m_axis_tlast,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [6:0] cfg_data_i
);

  localparam int AW    = $clog2(MAX_FFT_POINTS);
  localparam int NW    = AW + 1;
  localparam int SB    = SAMPLE_BITS;
  localparam int A_W   = SB + 1;
  localparam int ACC_W = A_W + stft_pkg::TW_W + AW + 2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_DFT  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [6:0] cfg_flen_q, cfg_hop_q;
  logic [2:0] cfg_l2_q;
  logic       cfg_taper_q;
  logic [6:0] seen_q, seen_d, hopc_q, hopc_d;
  logic [15:0] fcnt_q, fcnt_d, fr_q, fr_d;
  logic [AW-1:0] wptr_q, wptr_d;
  logic [NW-1:0] iss_q, iss_d, wr_q, wr_d;
  logic [AW-1:0] m_q, m_d;
  logic [5:0] ph_q, ph_d;
  logic iv_q, inwin_q, dv_q, df_q, dl_q;
  logic signed [stft_pkg::TW_W-1:0] tc_q, ts_q;
  logic signed [23:0] bre_q, bre_d, bim_q, bim_d;

  logic [2:0] l2;
  logic [NW-1:0] n_pts, flen;
  logic [6:0] flen7, hop7;
  logic in_acc, push, emit;
  logic signed [SB-1:0] in_re, in_im;
  logic [5:0] in_cidx;
  logic [15:0] in_cval;

  logic [2*SB-1:0] ring_rd;
  logic [15:0] tap_rd;
  logic [2*A_W-1:0] work_rd, work_wd;
  logic work_we;
  logic [AW-1:0] ring_ra, work_ra;

  stft_pkg::mac_ctrl_t mctl;
  logic signed [A_W-1:0] ma_re, ma_im;
  logic signed [stft_pkg::TW_W-1:0] mc, ms, wclamp;
  logic mres_v, mres_l;
  logic signed [ACC_W-1:0] acc_re, acc_im, rnd_re, rnd_im;
  logic prep_iss, dft_iss;

  assign in_re   = s_axis_tdata[SB-1:0];
  assign in_im   = s_axis_tdata[2*SB-1:SB];
  assign in_cidx = s_axis_tdata[2*SB+5:2*SB];
  assign in_cval = s_axis_tdata[2*SB+21:2*SB+6];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = (state_q == ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign push   = in_acc && (s_axis_tuser == stft_pkg::CMD_PUSH);

  always_comb begin
    if (cfg_l2_q < 3'd1) begin
      l2 = 3'd1;
    end else if (cfg_l2_q > 3'(AW)) begin
      l2 = 3'(AW);
    end else begin
      l2 = cfg_l2_q;
    end
    n_pts = NW'(1) << l2;
    flen7 = (cfg_flen_q < 7'd1) ? 7'd1 : cfg_flen_q;
    if (flen7 > 7'(n_pts)) begin
      flen7 = 7'(n_pts);
    end
    flen = NW'(flen7);
    hop7 = (cfg_hop_q < 7'd1) ? 7'd1 : cfg_hop_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_flen_q  <= 7'd64;
      cfg_hop_q   <= 7'd32;
      cfg_l2_q    <= 3'd6;
      cfg_taper_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        stft_pkg::REG_FRAME_LENGTH: cfg_flen_q  <= cfg_data_i;
        stft_pkg::REG_HOP_LENGTH:   cfg_hop_q   <= cfg_data_i;
        stft_pkg::REG_FFT_LOG2:     cfg_l2_q    <= cfg_data_i[2:0];
        stft_pkg::REG_TAPER_ENABLE: cfg_taper_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign prep_iss = (state_q == ST_PREP) && (iss_q < n_pts);
  assign dft_iss  = (state_q == ST_DFT) && (iss_q < n_pts);
  assign ring_ra  = wptr_q - flen[AW-1:0] + iss_q[AW-1:0];
  assign work_ra  = iss_q[AW-1:0];

  always_comb begin
    rnd_re = (acc_re + ACC_W'(16384)) >>> stft_pkg::SHIFT;
    rnd_im = (acc_im + ACC_W'(16384)) >>> stft_pkg::SHIFT;
    work_we = (state_q == ST_PREP) && mres_v;
    work_wd = {rnd_im[A_W-1:0], rnd_re[A_W-1:0]};
    bre_d = bre_q;
    bim_d = bim_q;
    if (rnd_re > ACC_W'(8388607)) begin
      bre_d = 24'sd8388607;
    end else if (rnd_re < -ACC_W'(8388608)) begin
      bre_d = -24'sd8388608;
    end else begin
      bre_d = rnd_re[23:0];
    end
    if (rnd_im > ACC_W'(8388607)) begin
      bim_d = 24'sd8388607;
    end else if (rnd_im < -ACC_W'(8388608)) begin
      bim_d = -24'sd8388608;
    end else begin
      bim_d = rnd_im[23:0];
    end
  end

  always_comb begin
    wclamp = (tap_rd > 16'd32768) ? stft_pkg::ONE_Q15 : stft_pkg::TW_W'(tap_rd);
    if (state_q == ST_PREP) begin
      mctl.valid = iv_q;
      mctl.first = 1'b1;
      mctl.last  = 1'b1;
      ma_re = inwin_q ? A_W'($signed(ring_rd[SB-1:0])) : '0;
      ma_im = inwin_q ? A_W'($signed(ring_rd[2*SB-1:SB])) : '0;
      mc    = cfg_taper_q ? wclamp : stft_pkg::ONE_Q15;
      ms    = '0;
    end else begin
      mctl.valid = dv_q;
      mctl.first = df_q;
      mctl.last  = dl_q;
      ma_re = work_rd[A_W-1:0];
      ma_im = work_rd[2*A_W-1:A_W];
      mc    = tc_q;
      ms    = ts_q;
    end
  end

  always_comb begin
    state_d = state_q;
    seen_d  = seen_q;
    hopc_d  = hopc_q;
    fcnt_d  = fcnt_q;
    fr_d    = fr_q;
    wptr_d  = wptr_q;
    iss_d   = iss_q;
    wr_d    = wr_q;
    m_d     = m_q;
    ph_d    = ph_q;
    emit    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (push) begin
          wptr_d = wptr_q + AW'(1);
          if (seen_q < flen7) begin
            seen_d = seen_q + 7'd1;
            if (seen_q + 7'd1 == flen7) begin
              emit = 1'b1;
            end
          end else if (hopc_q <= 7'd1) begin
            emit = 1'b1;
          end else begin
            hopc_d = hopc_q - 7'd1;
          end
          if (emit) begin
            hopc_d  = hop7;
            fr_d    = fcnt_q;
            state_d = ST_PREP;
            iss_d   = '0;
            wr_d    = '0;
            if (fcnt_q != 16'hFFFF) begin
              fcnt_d = fcnt_q + 16'd1;
            end
          end
          if (s_axis_tlast) begin
            seen_d = '0;
            hopc_d = '0;
            fcnt_d = '0;
          end
        end
      end
      ST_PREP: begin
        if (prep_iss) begin
          iss_d = iss_q + NW'(1);
        end
        if (mres_v) begin
          wr_d = wr_q + NW'(1);
          if (wr_q == n_pts - NW'(1)) begin
            state_d = ST_DFT;
            iss_d   = '0;
            m_d     = '0;
            ph_d    = '0;
          end
        end
      end
      ST_DFT: begin
        if (dft_iss) begin
          iss_d = iss_q + NW'(1);
          ph_d  = ph_q + (6'(m_q) << (3'd6 - l2));
        end
        if (mres_v && mres_l) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          if (NW'(m_q) == n_pts - NW'(1)) begin
            state_d = ST_IDLE;
          end else begin
            m_d     = m_q + AW'(1);
            iss_d   = '0;
            ph_d    = '0;
            state_d = ST_DFT;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seen_q  <= '0;
      hopc_q  <= '0;
      fcnt_q  <= '0;
      wptr_q  <= '0;
      iss_q   <= '0;
      wr_q    <= '0;
      m_q     <= '0;
      ph_q    <= '0;
      iv_q    <= 1'b0;
      dv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      seen_q  <= seen_d;
      hopc_q  <= hopc_d;
      fcnt_q  <= fcnt_d;
      wptr_q  <= wptr_d;
      iss_q   <= iss_d;
      wr_q    <= wr_d;
      m_q     <= m_d;
      ph_q    <= ph_d;
      iv_q    <= prep_iss;
      dv_q    <= dft_iss;
    end
  end

  always_ff @(posedge clk_i) begin
    fr_q    <= fr_d;
    inwin_q <= iss_q < flen;
    df_q    <= iss_q == '0;
    dl_q    <= iss_q == n_pts - NW'(1);
    tc_q    <= stft_pkg::cos64(ph_q);
    ts_q    <= stft_pkg::sin64(ph_q);
    if (state_q == ST_DFT && mres_v && mres_l) begin
      bre_q <= bre_d;
      bim_q <= bim_d;
    end
  end

  stft_ram #(.W(2*SB), .D(MAX_FFT_POINTS)) u_ring (
    .clk_i(clk_i), .we_i(push), .waddr_i(wptr_q),
    .wdata_i({in_im, in_re}), .raddr_i(ring_ra), .rdata_o(ring_rd)
  );

  stft_ram #(.W(16), .D(MAX_FFT_POINTS)) u_taper (
    .clk_i(clk_i), .we_i(in_acc && (s_axis_tuser == stft_pkg::CMD_LOAD)),
    .waddr_i(in_cidx[AW-1:0]), .wdata_i(in_cval),
    .raddr_i(iss_q[AW-1:0]), .rdata_o(tap_rd)
  );

  stft_ram #(.W(2*A_W), .D(MAX_FFT_POINTS)) u_work (
    .clk_i(clk_i), .we_i(work_we), .waddr_i(wr_q[AW-1:0]),
    .wdata_i(work_wd), .raddr_i(work_ra), .rdata_o(work_rd)
  );

  stft_mac #(.A_W(A_W), .ACC_W(ACC_W)) u_mac (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(mctl),
    .a_re_i(ma_re), .a_im_i(ma_im), .c_i(mc), .s_i(ms),
    .res_valid_o(mres_v), .res_last_o(mres_l),
    .acc_re_o(acc_re), .acc_im_o(acc_im)
  );

  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {2'b00, fr_q, 6'(m_q), bim_q, bre_q};
  assign m_axis_tlast  = (NW'(m_q) == n_pts - NW'(1));

endmodule

// ===== hw/rtl/stft_checker.sv =====
// Port-level checker for the complex STFT spectrogram, bound to the top level.
// It depends only on the top level's ports.
module stft_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Stalled result transaction changed.");

  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("Input taken while a result waits.");

  a_more_bins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
    else $error("Input taken before the last bin of a window.");

  a_no_instant_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("Result appeared one cycle after an input transaction.");

endmodule

bind complex_stft_spectrogram stft_checker u_stft_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
